>>> hw/rtl/dsp_pkg.sv
// shared types and constants for the dense shortest paths unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package dsp_pkg;

  localparam int MAX_NODES     = 64;
  localparam int NODE_BITS     = $clog2(MAX_NODES);
  localparam int CNT_BITS      = NODE_BITS + 1;
  localparam int WEIGHT_BITS   = 32;
  localparam int MAT_DEPTH     = MAX_NODES * MAX_NODES;
  localparam int MAT_ADDR_BITS = 2 * NODE_BITS;

  localparam logic [WEIGHT_BITS-1:0] INF_WEIGHT = {WEIGHT_BITS{1'b1}};

  // request kinds on the input channel
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // datapath commands
  localparam int OP_BITS = 3;
  localparam logic [OP_BITS-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INIT   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SCAN   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_MARK   = 3'd4;
  localparam logic [OP_BITS-1:0] OP_RELAX  = 3'd5;
  localparam logic [OP_BITS-1:0] OP_OUT_RD = 3'd6;
  localparam logic [OP_BITS-1:0] OP_OUT_LD = 3'd7;

  typedef struct packed {
    logic                   req_type;
    logic [NODE_BITS-1:0]   from_node;
    logic [NODE_BITS-1:0]   to_node;
    logic [WEIGHT_BITS-1:0] weight;
    logic [NODE_BITS-1:0]   source_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   node_index;
    logic [WEIGHT_BITS-1:0] distance;
    logic                   reachable;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [NODE_BITS-1:0] idx;
    logic                 zero;
    logic                 last;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/dsp_datapath.sv
// datapath: weight matrix memory, distance memory, visited bits,
// minimum scan, relaxation adder and output register; uses dsp_pkg
`timescale 1ns / 1ps

module dsp_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dsp_pkg::in_item_t  in_data,
  input  dsp_pkg::dp_cmd_t   cmd,
  output dsp_pkg::dp_status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output dsp_pkg::out_item_t out_data
);

  logic [dsp_pkg::WEIGHT_BITS-1:0] mat_mem [0:dsp_pkg::MAT_DEPTH-1];
  logic [dsp_pkg::WEIGHT_BITS-1:0] dist_mem [0:dsp_pkg::MAX_NODES-1];
  logic [dsp_pkg::WEIGHT_BITS-1:0] mat_rdata;
  logic [dsp_pkg::WEIGHT_BITS-1:0] dist_rdata;
  logic [dsp_pkg::MAX_NODES-1:0]   done_bits;

  logic [dsp_pkg::OP_BITS-1:0]     st_op;
  logic [dsp_pkg::NODE_BITS-1:0]   st_idx;

  logic [dsp_pkg::WEIGHT_BITS-1:0] least;
  logic [dsp_pkg::NODE_BITS-1:0]   pick;
  logic                            found;

  logic                            st_first;
  logic [dsp_pkg::WEIGHT_BITS-1:0] scan_bound;
  logic                            scan_hit;
  logic [dsp_pkg::WEIGHT_BITS:0]   sum;
  logic                            relax_hit;
  logic                            init_we;
  logic                            dist_we;
  logic [dsp_pkg::NODE_BITS-1:0]   dist_waddr;
  logic [dsp_pkg::WEIGHT_BITS-1:0] dist_wdata;
  logic                            out_free;
  logic                            out_load;

  assign st_first   = (st_idx == '0);
  assign scan_bound = st_first ? dsp_pkg::INF_WEIGHT : least;
  assign scan_hit   = (st_op == dsp_pkg::OP_SCAN) && !done_bits[st_idx] &&
                      (dist_rdata < scan_bound);

  assign sum       = {1'b0, least} + {1'b0, mat_rdata};
  assign relax_hit = (st_op == dsp_pkg::OP_RELAX) && !done_bits[st_idx] &&
                     (mat_rdata != dsp_pkg::INF_WEIGHT) &&
                     (sum < {1'b0, dsp_pkg::INF_WEIGHT}) &&
                     (sum[dsp_pkg::WEIGHT_BITS-1:0] < dist_rdata);

  assign init_we    = (cmd.op == dsp_pkg::OP_INIT);
  assign dist_we    = init_we || relax_hit;
  assign dist_waddr = init_we ? cmd.idx : st_idx;
  assign dist_wdata = init_we ? (cmd.zero ? '0 : dsp_pkg::INF_WEIGHT)
                              : sum[dsp_pkg::WEIGHT_BITS-1:0];

  assign out_free = !out_valid || !out_stall;
  assign out_load = (cmd.op == dsp_pkg::OP_OUT_LD) && out_free;

  assign status.found    = found;
  assign status.out_free = out_free;

  // weight matrix: written by load beats, read along the picked row
  always_ff @(posedge clk) begin
    if (cmd.op == dsp_pkg::OP_LOAD) begin
      mat_mem[{in_data.from_node, in_data.to_node}] <= in_data.weight;
    end
    mat_rdata <= mat_mem[{pick, cmd.idx}];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rdata <= dist_mem[cmd.idx];
  end

  // stage aligned with the registered memory reads
  always_ff @(posedge clk) begin
    if (rst) begin
      st_op <= dsp_pkg::OP_NONE;
    end else begin
      st_op <= cmd.op;
    end
    st_idx <= cmd.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_bits <= '0;
    end else if (init_we && cmd.idx == '0) begin
      done_bits <= '0;
    end else if (cmd.op == dsp_pkg::OP_MARK) begin
      done_bits[pick] <= 1'b1;
    end
  end

  // running minimum over unvisited nodes, lowest index wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (st_op == dsp_pkg::OP_SCAN) begin
      found <= st_first ? scan_hit : (found || scan_hit);
    end
    if (st_op == dsp_pkg::OP_SCAN) begin
      least <= scan_hit ? dist_rdata : scan_bound;
      if (scan_hit) begin
        pick <= st_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.node_index <= cmd.idx;
      out_data.distance   <= dist_rdata;
      out_data.reachable  <= (dist_rdata != dsp_pkg::INF_WEIGHT);
      out_data.last       <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/dsp_ctrl.sv
// controller: run sequencing (init sweep, scan, relax rounds, readout),
// node count register and input handshake; uses dsp_pkg
`timescale 1ns / 1ps

module dsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dsp_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data,
  input  dsp_pkg::dp_status_t status,
  output dsp_pkg::dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_SCAN_END  = 4'd4;
  localparam logic [3:0] S_DECIDE    = 4'd5;
  localparam logic [3:0] S_RELAX     = 4'd6;
  localparam logic [3:0] S_RELAX_END = 4'd7;
  localparam logic [3:0] S_OUT_RD    = 4'd8;
  localparam logic [3:0] S_OUT_LD    = 4'd9;

  localparam logic [dsp_pkg::CNT_BITS-1:0] CNT_MAX =
    dsp_pkg::CNT_BITS'(dsp_pkg::MAX_NODES);
  localparam logic [dsp_pkg::CNT_BITS-1:0] CNT_ONE = dsp_pkg::CNT_BITS'(1);

  logic [3:0]                     state, state_next;
  logic [6:0]                     node_count;
  logic [dsp_pkg::CNT_BITS-1:0]   n_run, n_run_next;
  logic [dsp_pkg::CNT_BITS-1:0]   cnt, cnt_next;
  logic [dsp_pkg::CNT_BITS-1:0]   round_cnt, round_cnt_next;
  logic [dsp_pkg::NODE_BITS-1:0]  src, src_next;
  logic [dsp_pkg::CNT_BITS-1:0]   n_eff;
  logic                           cnt_last;
  logic                           accept;

  assign n_eff = (node_count == '0) ? CNT_ONE :
                 (node_count > CNT_MAX) ? CNT_MAX : node_count;

  assign cnt_last  = (cnt == n_run - CNT_ONE);
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next     = state;
    n_run_next     = n_run;
    cnt_next       = cnt;
    round_cnt_next = round_cnt;
    src_next       = src;
    cmd.op         = dsp_pkg::OP_NONE;
    cmd.idx        = cnt[dsp_pkg::NODE_BITS-1:0];
    cmd.zero       = (cnt[dsp_pkg::NODE_BITS-1:0] == src) && ({1'b0, src} < n_run);
    cmd.last       = cnt_last;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == dsp_pkg::REQ_LOAD) begin
            cmd.op = dsp_pkg::OP_LOAD;
          end else begin
            n_run_next = n_eff;
            src_next   = in_data.source_node;
            cnt_next   = '0;
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.op = dsp_pkg::OP_INIT;
        if (cnt_last) begin
          cnt_next       = '0;
          round_cnt_next = '0;
          state_next     = S_CHECK;
        end else begin
          cnt_next = cnt + CNT_ONE;
        end
      end
      S_CHECK: begin
        cnt_next   = '0;
        state_next = (round_cnt + CNT_ONE >= n_run) ? S_OUT_RD : S_SCAN;
      end
      S_SCAN: begin
        cmd.op = dsp_pkg::OP_SCAN;
        if (cnt_last) begin
          state_next = S_SCAN_END;
        end else begin
          cnt_next = cnt + CNT_ONE;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_next = '0;
        if (status.found) begin
          cmd.op         = dsp_pkg::OP_MARK;
          round_cnt_next = round_cnt + CNT_ONE;
          state_next     = S_RELAX;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_RELAX: begin
        cmd.op = dsp_pkg::OP_RELAX;
        if (cnt_last) begin
          state_next = S_RELAX_END;
        end else begin
          cnt_next = cnt + CNT_ONE;
        end
      end
      S_RELAX_END: begin
        // last relaxation write lands in this cycle
        state_next = S_CHECK;
      end
      S_OUT_RD: begin
        cmd.op     = dsp_pkg::OP_OUT_RD;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.op = dsp_pkg::OP_OUT_LD;
        if (status.out_free) begin
          if (cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cnt_next   = cnt + CNT_ONE;
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= 7'(dsp_pkg::MAX_NODES);
      n_run      <= CNT_MAX;
      cnt        <= '0;
      round_cnt  <= '0;
      src        <= '0;
    end else begin
      state     <= state_next;
      n_run     <= n_run_next;
      cnt       <= cnt_next;
      round_cnt <= round_cnt_next;
      src       <= src_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
    end
  end

endmodule

>>> hw/rtl/dense_shortest_paths_unit.sv
// load beats are taken back to back. a run beat with n active nodes does an init sweep,
// then up to n-1 rounds (one distance-memory scan and one weight-row relaxation
// pass each), then reads the results out
// one item at a time; input stalls while a run is in progress
// rst (synchronous) clears control, visited bits and the output register and sets
// node_count to 64; weight and distance memories keep their contents
`timescale 1ns / 1ps

module dense_shortest_paths_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  dsp_pkg::dp_cmd_t    cmd;
  dsp_pkg::dp_status_t status;

  dsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  dsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/dsp_checker.sv
// port-level checks for the dense shortest paths unit, bound to the top level
// depends on dsp_pkg and dense_shortest_paths_unit
`timescale 1ns / 1ps

module dsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input dsp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dsp_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reach_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.reachable == (out_data.distance != dsp_pkg::INF_WEIGHT))
    else $error("reachable flag disagrees with distance");

  // a run keeps the input side busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.req_type == dsp_pkg::REQ_RUN) |=> in_stall)
    else $error("input taken right after a run beat");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown after reset");

endmodule

bind dense_shortest_paths_unit dsp_checker u_dsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
